// File: rtl/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

  // Store geometry
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int KEY_W     = 32;
  localparam int STAT_W    = 32;

  // Packed output data: key, compare count, move count (lowest bits first)
  localparam int DATA_W    = KEY_W + 2 * STAT_W;

  // Increments applied to the statistics counters
  localparam logic [1:0] CMP_ONE  = 2'd1;
  localparam logic [1:0] CMP_TWO  = 2'd2;
  localparam logic [1:0] MOVE_INC = 2'd3;

  // One sorted result word from the sequencer to the output stage
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              last;
    logic [STAT_W-1:0] cmp;
    logic [STAT_W-1:0] mov;
    logic              drop;
  } emit_word_t;

  // Saturating counter add
  function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                input logic [1:0] b);
    logic [STAT_W:0] s;
    s = {1'b0, a} + {{(STAT_W - 1){1'b0}}, b};
    return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/heap_sort_counted_top.sv
`default_nettype none

// Heapsort of up to 64 signed 32-bit keys held in one dual-read RAM. Keys
// stream in one word per cycle; the word with tlast closes the set and starts
// the sort (keys past 64 are dropped and tuser is set on every result of that
// run). The heap is built by sift-down and then drained root by root; each
// sift level is a child read followed by a compare and write back on the
// RAM's registered read ports, after which the keys leave in ascending order,
// one word at a time, each read from the RAM before it is offered. No new key
// is taken until the last result of a run has entered the output register.
// Each result carries the run's saturating compare and move totals.
module heap_sort_counted_top import hsc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [KEY_W-1:0]  s_axis_tdata_i,  // [31:0] key
  input  wire logic              s_axis_tlast_i,  // last_item
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [DATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_key, [63:32] compare_count,
                                                  // [95:64] move_count
  output logic                   m_axis_tlast_o,  // last_of_run
  output logic                   m_axis_tuser_o   // dropped
);

  logic       emit_valid, emit_ready;
  emit_word_t emit_word;
  logic       out_valid_q;
  emit_word_t out_word_q;

  hsc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_key_i     (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .emit_valid_o (emit_valid),
    .emit_word_o  (emit_word),
    .emit_ready_i (emit_ready)
  );

  // Output register: free when empty or being drained
  assign emit_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && emit_valid) begin
      out_word_q <= emit_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_word_q.mov, out_word_q.cmp, out_word_q.key};
  assign m_axis_tlast_o  = out_word_q.last;
  assign m_axis_tuser_o  = out_word_q.drop;

endmodule

`default_nettype wire

// File: rtl/hsc_ram.sv
`default_nettype none

// One write port, two registered read ports; read data holds when not enabled.
module hsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsc_core.sv
`default_nettype none

module hsc_core import hsc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // load side
  input  wire logic             in_valid_i,
  input  wire logic [KEY_W-1:0] in_key_i,
  input  wire logic             in_last_i,
  output logic                  in_ready_o,
  // result side
  output logic                  emit_valid_o,
  output emit_word_t            emit_word_o,
  input  wire logic             emit_ready_i
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_BSTART,
    S_BLOAD,
    S_SREAD,
    S_SCMP,
    S_TSTART,
    S_TSWAP,
    S_ORD,
    S_OWR
  } state_e;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;     // keys stored
  logic              ovf_q, ovf_d;
  logic [STAT_W-1:0] cmp_q, cmp_d;
  logic [STAT_W-1:0] mov_q, mov_d;
  logic [CNT_W-1:0]  n_q, n_d;         // keys in this run
  logic [CNT_W-1:0]  bi_q, bi_d;       // build: next node + 1
  logic [CNT_W-1:0]  ti_q, ti_d;       // extract: heap size before swap
  logic [IDX_W-1:0]  p_q, p_d;         // sift position (hole)
  logic [CNT_W-1:0]  sz_q, sz_d;       // sift heap size
  logic [KEY_W-1:0]  v_q, v_d;         // key being sifted
  logic              build_q, build_d;
  logic [CNT_W-1:0]  k_q, k_d;         // output index

  // RAM controls
  logic             we, re;
  logic [IDX_W-1:0] wa, ra, rb;
  logic [KEY_W-1:0] wd;
  logic [KEY_W-1:0] rdata_a, rdata_b;

  hsc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .re_i      (re),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Child indices and the sift compare
  logic [CNT_W:0]   left_w, right_w, sz_w;
  logic             l_ok, r_ok, l_gt, r_gt;
  logic [KEY_W-1:0] lmax;
  logic [IDX_W-1:0] child;

  assign left_w  = {1'b0, p_q, 1'b1};
  assign right_w = left_w + (CNT_W + 1)'(1);
  assign sz_w    = {1'b0, sz_q};
  assign l_ok    = left_w < sz_w;
  assign r_ok    = right_w < sz_w;
  assign l_gt    = $signed(rdata_a) > $signed(v_q);
  assign lmax    = l_gt ? rdata_a : v_q;
  assign r_gt    = r_ok && ($signed(rdata_b) > $signed(lmax));
  assign child   = r_gt ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

  assign in_ready_o = (state_q == S_LOAD);

  // Result word straight off the RAM read port
  always_comb begin
    emit_word_o.key  = rdata_a;
    emit_word_o.last = (k_q + CNT_W'(1)) == n_q;
    emit_word_o.cmp  = cmp_q;
    emit_word_o.mov  = mov_q;
    emit_word_o.drop = ovf_q;
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    cmp_d        = cmp_q;
    mov_d        = mov_q;
    n_d          = n_q;
    bi_d         = bi_q;
    ti_d         = ti_q;
    p_d          = p_q;
    sz_d         = sz_q;
    v_d          = v_q;
    build_d      = build_q;
    k_d          = k_q;
    we           = 1'b0;
    wa           = p_q;
    wd           = v_q;
    re           = 1'b0;
    ra           = p_q;
    rb           = p_q;
    emit_valid_o = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q != MAX_CNT) begin
            we    = 1'b1;
            wa    = cnt_q[IDX_W-1:0];
            wd    = in_key_i;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            n_d     = cnt_d;
            bi_d    = cnt_d >> 1;
            ti_d    = cnt_d;
            state_d = S_BSTART;
          end
        end
      end

      // heap build: sift-down from the middle toward the root
      S_BSTART: begin
        if (bi_q == '0) begin
          state_d = S_TSTART;
        end else begin
          re      = 1'b1;
          ra      = IDX_W'(bi_q - CNT_W'(1));
          p_d     = IDX_W'(bi_q - CNT_W'(1));
          sz_d    = n_q;
          build_d = 1'b1;
          state_d = S_BLOAD;
        end
      end

      S_BLOAD: begin
        v_d     = rdata_a;
        state_d = S_SREAD;
      end

      // fetch both children, or park the key when the hole is a leaf
      S_SREAD: begin
        if (!l_ok) begin
          we = 1'b1;
          if (build_q) begin
            bi_d    = bi_q - CNT_W'(1);
            state_d = S_BSTART;
          end else begin
            state_d = S_TSTART;
          end
        end else begin
          re      = 1'b1;
          ra      = left_w[IDX_W-1:0];
          rb      = right_w[IDX_W-1:0];
          state_d = S_SCMP;
        end
      end

      S_SCMP: begin
        cmp_d = sat_add(cmp_q, r_ok ? CMP_TWO : CMP_ONE);
        we    = 1'b1;
        if (l_gt || r_gt) begin
          wd      = r_gt ? rdata_b : rdata_a;
          mov_d   = sat_add(mov_q, MOVE_INC);
          p_d     = child;
          state_d = S_SREAD;
        end else if (build_q) begin
          bi_d    = bi_q - CNT_W'(1);
          state_d = S_BSTART;
        end else begin
          state_d = S_TSTART;
        end
      end

      // extraction: swap root with the last heap entry
      S_TSTART: begin
        if (ti_q == '0) begin
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          re      = 1'b1;
          ra      = '0;
          rb      = IDX_W'(ti_q - CNT_W'(1));
          build_d = 1'b0;
          state_d = S_TSWAP;
        end
      end

      S_TSWAP: begin
        we      = 1'b1;
        wa      = IDX_W'(ti_q - CNT_W'(1));
        wd      = rdata_a;
        v_d     = rdata_b;
        mov_d   = sat_add(mov_q, MOVE_INC);
        p_d     = '0;
        sz_d    = ti_q - CNT_W'(1);
        ti_d    = ti_q - CNT_W'(1);
        state_d = S_SREAD;
      end

      // read out in ascending order
      S_ORD: begin
        re      = 1'b1;
        ra      = k_q[IDX_W-1:0];
        state_d = S_OWR;
      end

      S_OWR: begin
        if (emit_ready_i) begin
          emit_valid_o = 1'b1;
          k_d          = k_q + CNT_W'(1);
          if (emit_word_o.last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            cmp_d   = '0;
            mov_d   = '0;
            state_d = S_LOAD;
          end else begin
            state_d = S_ORD;
          end
        end
      end

      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      cmp_q   <= '0;
      mov_q   <= '0;
      n_q     <= '0;
      bi_q    <= '0;
      ti_q    <= '0;
      p_q     <= '0;
      sz_q    <= '0;
      build_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      cmp_q   <= cmp_d;
      mov_q   <= mov_d;
      n_q     <= n_d;
      bi_q    <= bi_d;
      ti_q    <= ti_d;
      p_q     <= p_d;
      sz_q    <= sz_d;
      build_q <= build_d;
      k_q     <= k_d;
    end
  end

  // sifted key needs no reset
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  // Store fill never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= MAX_CNT)
    else $error("hsc_core: item count beyond capacity");

  // A compared hole always has a left child inside the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == S_SCMP) |-> l_ok)
    else $error("hsc_core: compare without a child");

  // Last result of a run clears all run statistics
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && emit_word_o.last) |=>
      (cnt_q == '0 && cmp_q == '0 && mov_q == '0 && !ovf_q))
    else $error("hsc_core: run state not cleared");

  // Output index stays inside the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OWR) |-> (k_q < n_q))
    else $error("hsc_core: output index beyond run");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  localparam int RUN_LIMIT   = 200000;  // cycles before the run is declared hung
  localparam int HOLD_CYCLES = 2000;    // long receiver back-pressure stretch
  localparam int ITEM_GOAL   = 460;

  typedef enum int {KEYS_RANDOM, KEYS_NARROW, KEYS_RISING, KEYS_EXTREME} key_style_e;

  // Heapsort predictor and queue of expected sorted words
  class sort_scoreboard;
    logic signed [KEY_W-1:0] keys[MAX_ITEMS];
    int unsigned             fill;
    bit                      overflow;
    logic [STAT_W-1:0]       cmp_total;
    logic [STAT_W-1:0]       mov_total;
    emit_word_t              sorted_q[$];
    int                      errors;

    function new();
      fill      = 0;
      overflow  = 0;
      cmp_total = '0;
      mov_total = '0;
      errors    = 0;
    endfunction

    // saturating counter step
    function logic [STAT_W-1:0] bump(logic [STAT_W-1:0] v, int unsigned inc);
      logic [STAT_W:0] s;
      s = {1'b0, v} + inc;
      return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
    endfunction

    function void exchange(int unsigned a, int unsigned b);
      logic signed [KEY_W-1:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
      mov_total = bump(mov_total, 3);
    endfunction

    function void sift(int unsigned heap_size, int unsigned node);
      int unsigned big;
      int unsigned lc;
      int unsigned rc;
      bit          more;
      more = 1;
      while (more) begin
        big = node;
        lc  = 2 * node + 1;
        rc  = 2 * node + 2;
        if (lc < heap_size) begin
          cmp_total = bump(cmp_total, 1);
          if (keys[lc] > keys[big]) big = lc;
        end
        if (rc < heap_size) begin
          cmp_total = bump(cmp_total, 1);
          if (keys[rc] > keys[big]) big = rc;
        end
        if (big == node) begin
          more = 0;
        end else begin
          exchange(node, big);
          node = big;
        end
      end
    endfunction

    // accepted input word: store the key, sort and queue results on tlast
    function void note_key(logic [KEY_W-1:0] k, logic l);
      int unsigned i;
      emit_word_t  w;
      if (fill < MAX_ITEMS) begin
        keys[fill] = k;
        fill++;
      end else begin
        overflow = 1;
      end
      if (!l) return;
      cmp_total = '0;
      mov_total = '0;
      for (i = fill / 2; i > 0; i--) sift(fill, i - 1);
      for (i = fill; i > 0; i--) begin
        exchange(0, i - 1);
        sift(i - 1, 0);
      end
      for (i = 0; i < fill; i++) begin
        w.key  = keys[i];
        w.last = (i + 1 == fill);
        w.cmp  = cmp_total;
        w.mov  = mov_total;
        w.drop = overflow;
        sorted_q.push_back(w);
      end
      fill      = 0;
      overflow  = 0;
      cmp_total = '0;
      mov_total = '0;
    endfunction

    // accepted output word: compare with the oldest expectation
    function void check_word(emit_word_t got);
      emit_word_t exp_w;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected word key=%h last=%b cmp=%h mov=%h drop=%b", $time,
                 got.key, got.last, got.cmp, got.mov, got.drop);
        errors++;
        return;
      end
      exp_w = sorted_q.pop_front();
      if (got.key !== exp_w.key) begin
        $display("%0t: sorted_key expected %h actual %h", $time, exp_w.key, got.key);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, exp_w.last, got.last);
        errors++;
      end
      if (got.cmp !== exp_w.cmp) begin
        $display("%0t: compare_count expected %h actual %h", $time, exp_w.cmp, got.cmp);
        errors++;
      end
      if (got.mov !== exp_w.mov) begin
        $display("%0t: move_count expected %h actual %h", $time, exp_w.mov, got.mov);
        errors++;
      end
      if (got.drop !== exp_w.drop) begin
        $display("%0t: dropped expected %b actual %b", $time, exp_w.drop, got.drop);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_valid;
  logic [KEY_W-1:0]  s_data;
  logic              s_last;
  logic              m_ready;
  wire               s_axis_tready_o;
  wire               m_axis_tvalid_o;
  wire  [DATA_W-1:0] m_axis_tdata_o;
  wire               m_axis_tlast_o;
  wire               m_axis_tuser_o;

  sort_scoreboard sb = new();

  int  send_gap_pct;
  int  recv_gap_pct;
  int  items_sent;
  int  cycles;
  bit  pressure_go;
  bit  hold_rx;

  heap_sort_counted_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hang guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > RUN_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted here once triggered
  initial begin
    hold_rx <= 1'b0;
    wait (pressure_go);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Receiver: check accepted words, then pick next tready
  initial begin
    emit_word_t got;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_ready) begin
        got.key  = m_axis_tdata_o[KEY_W-1:0];
        got.last = m_axis_tlast_o;
        got.cmp  = m_axis_tdata_o[KEY_W +: STAT_W];
        got.mov  = m_axis_tdata_o[KEY_W + STAT_W +: STAT_W];
        got.drop = m_axis_tuser_o;
        sb.check_word(got);
      end
      if (hold_rx) m_ready <= 1'b0;
      else         m_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Offer one key word, with random idle cycles first
  task automatic send_word(input logic [KEY_W-1:0] k, input logic l);
    while ($urandom_range(99) < send_gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= k;
    s_last  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_key(k, l);
    items_sent++;
  endtask

  // One run of keys; tlast on the final word
  task automatic send_run(input int count, input key_style_e style);
    logic [KEY_W-1:0] base_key;
    logic [KEY_W-1:0] k;
    int               i;
    base_key = $urandom;
    for (i = 0; i < count; i++) begin
      case (style)
        KEYS_NARROW:  k = $urandom_range(6) - 3;
        KEYS_RISING:  k = base_key + i;
        KEYS_EXTREME: begin
          case ($urandom_range(3))
            0:       k = 32'h8000_0000;
            1:       k = 32'h7fff_ffff;
            2:       k = 32'hffff_ffff;
            default: k = $urandom;
          endcase
        end
        default:      k = $urandom;
      endcase
      send_word(k, i == count - 1);
    end
  endtask

  // Idle mix follows progress through the stimulus
  task automatic pick_idle();
    if (items_sent < ITEM_GOAL / 3) begin
      send_gap_pct = 15;
      recv_gap_pct = 76;
    end else if (items_sent < 2 * ITEM_GOAL / 3) begin
      send_gap_pct = 76;
      recv_gap_pct = 15;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
  endtask

  // Main sequence
  initial begin
    int         run_no;
    int         len;
    key_style_e style;
    rst_ni       <= 1'b0;
    s_valid      <= 1'b0;
    s_data       <= '0;
    s_last       <= 1'b0;
    items_sent   = 0;
    pressure_go  = 0;
    run_no       = 0;
    pick_idle();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single key runs at both extremes
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7fff_ffff, 1'b1);
    // two keys, reversed extremes
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    // around zero
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    // all keys equal
    repeat (3) send_word(32'd5, 1'b0);
    send_word(32'd5, 1'b1);
    // extremes with ties
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    // strictly falling keys
    send_word(32'd600, 1'b0);
    send_word(32'd500, 1'b0);
    send_word(32'd400, 1'b0);
    send_word(32'hffff_ff00, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h8000_0000, 1'b1);

    // random runs; a few fill the store or run past it
    while (items_sent < ITEM_GOAL) begin
      pick_idle();
      if (!pressure_go && items_sent >= 2 * ITEM_GOAL / 3) pressure_go = 1;
      case (run_no)
        3:       len = MAX_ITEMS;          // exactly full
        15:      len = MAX_ITEMS + 1;      // tlast word itself dropped
        30:      len = MAX_ITEMS + 6;      // several dropped
        default: len = ($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
      endcase
      case ($urandom_range(5))
        0:       style = KEYS_NARROW;
        1:       style = KEYS_RISING;
        2:       style = KEYS_EXTREME;
        default: style = KEYS_RANDOM;
      endcase
      send_run(len, style);
      run_no++;
    end
    s_valid <= 1'b0;

    // drain, then a quiet stretch to catch stray words
    while (sb.sorted_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/hsc_pkg.sv
rtl/hsc_ram.sv
rtl/hsc_core.sv
rtl/heap_sort_counted_top.sv
dv/testbench.sv
